// ===== rtl/core/positional_linked_list_engine_top_macros.svh =====
// Assertion macros for the positional linked list engine.
// Used by positional_linked_list_engine_top; expects clk and arst_n in scope.
`ifndef POSITIONAL_LINKED_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_LINKED_LIST_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PLLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PLLE_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PLLE_ASSERT(lbl, prop, msg)
`define PLLE_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/core/plle_pkg.sv =====
// Package of the positional linked list engine: field widths, operation and status codes.
// Has no dependencies; used by positional_linked_list_engine_top.
package plle_pkg;

	localparam int CAPACITY_DEFAULT   = 256;
	localparam int DATA_WIDTH_DEFAULT = 32;

	localparam int MODE_W    = 3;
	localparam int POS_W     = 9;
	localparam int VALUE_W   = 32;
	localparam int STATUS_W  = 2;
	localparam int RV_W      = 32;
	localparam int LEN_W     = 9;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 48;

	localparam logic [MODE_W-1:0] MODE_READ       = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

// ===== rtl/core/positional_linked_list_engine_top.sv =====
// Path to the result handshake: the walk to list position k, then ST_LINK_S and ST_LINK_N
// for an insert or push, ST_DEL_Q and ST_DEL_N for a delete; a rejected item skips the walk.
// Throughput: one item at a time; the link walk reads one node per cycle from the node memory.
// Reset: asynchronous, active low; after release a pass over the CAPACITY+1 node entries
// builds the free chain and the sentinel before the first item is accepted.
// Depends on plle_pkg and positional_linked_list_engine_top_macros.svh.
`include "positional_linked_list_engine_top_macros.svh"

module positional_linked_list_engine_top #(
	parameter int CAPACITY   = plle_pkg::CAPACITY_DEFAULT,
	parameter int DATA_WIDTH = plle_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// Fields from bit 0: mode[2:0], position[11:3], value[43:12], zero pad[47:44].
	input  logic [plle_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// Fields from bit 0: status[1:0], read_value[33:2], length[42:34], empty_res[43], pad[47:44].
	output logic [plle_pkg::M_TDATA_W-1:0]  m_tdata
);

	localparam int LW    = $clog2(CAPACITY + 1);
	localparam int PW    = plle_pkg::POS_W;
	localparam int CMPW  = ((LW > PW) ? LW : PW) + 1;
	localparam int OLW   = plle_pkg::LEN_W;
	localparam int RVW   = plle_pkg::RV_W;
	localparam int PADW  = plle_pkg::M_TDATA_W - plle_pkg::STATUS_W - RVW - OLW - 1;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] val;
		logic [LW-1:0]         nxt;
		logic [LW-1:0]         prv;
	} node_t;

	typedef enum logic [7:0] {
		ST_INIT   = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_WALK   = 8'b0000_0100,
		ST_DEL_Q  = 8'b0000_1000,
		ST_DEL_N  = 8'b0001_0000,
		ST_LINK_S = 8'b0010_0000,
		ST_LINK_N = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	node_t mem [0:CAPACITY];
	node_t rd_data_q;

	state_t state_q, state_d;

	logic [LW-1:0]   init_cnt_q;
	logic [LW-1:0]   free_head_q;
	logic [LW-1:0]   len_q;
	logic [LW-1:0]   p_q, q_q, n_q;
	logic [CMPW-1:0] steps_q;
	logic            back_q;
	logic            out_valid_q;

	logic [plle_pkg::MODE_W-1:0]   mode_q;
	logic [plle_pkg::VALUE_W-1:0]  val_q;
	logic [plle_pkg::STATUS_W-1:0] status_q;
	logic [RVW-1:0]                rv_q;
	logic [plle_pkg::M_TDATA_W-1:0] out_data_q;

	logic [plle_pkg::MODE_W-1:0]  in_mode;
	logic [PW-1:0]                in_pos;
	logic [plle_pkg::VALUE_W-1:0] in_value;

	logic                          accept;
	logic [CMPW-1:0]               pos_w, len_w, tgt, steps_init;
	logic                          rej, back_init, full;
	logic [plle_pkg::STATUS_W-1:0] rej_status;

	logic          rd_en;
	logic [LW-1:0] rd_addr;
	logic          wr_val, wr_nxt, wr_prv;
	logic [LW-1:0] wr_addr;
	node_t         wr_data;

	logic                 walk_end, del_op, read_op, out_load;
	logic [LW-1:0]        walk_next;
	logic signed [63:0]   val_ext;

	assign in_mode  = s_tdata[2:0];
	assign in_pos   = s_tdata[11:3];
	assign in_value = s_tdata[43:12];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign full      = (free_head_q == '0);
	assign walk_end  = (steps_q == '0);
	assign walk_next = back_q ? rd_data_q.prv : rd_data_q.nxt;
	assign read_op   = (mode_q == plle_pkg::MODE_READ);
	assign del_op    = (mode_q == plle_pkg::MODE_DELETE);
	assign val_ext   = 64'($signed(rd_data_q.val));
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	// Target node of the walk: the element itself for read and delete, the node to link
	// after for insert and push. The shorter way around the ring is taken.
	always_comb begin
		pos_w      = CMPW'(in_pos);
		len_w      = CMPW'(len_q);
		tgt        = '0;
		rej        = 1'b0;
		rej_status = plle_pkg::STATUS_RANGE;
		unique case (in_mode)
			plle_pkg::MODE_READ, plle_pkg::MODE_DELETE: begin
				tgt = pos_w;
				rej = (pos_w == '0) || (pos_w > len_w);
			end
			plle_pkg::MODE_INSERT: begin
				tgt = pos_w - 1'b1;
				if ((pos_w == '0) || (pos_w > len_w + 1'b1)) begin
					rej = 1'b1;
				end else if (full) begin
					rej        = 1'b1;
					rej_status = plle_pkg::STATUS_FULL;
				end
			end
			plle_pkg::MODE_PUSH_FRONT, plle_pkg::MODE_PUSH_BACK: begin
				tgt = (in_mode == plle_pkg::MODE_PUSH_BACK) ? len_w : '0;
				if (full) begin
					rej        = 1'b1;
					rej_status = plle_pkg::STATUS_FULL;
				end
			end
			default: begin
				rej = 1'b1;
			end
		endcase
		back_init  = tgt > (len_w - tgt);
		steps_init = back_init ? (len_w + 1'b1 - tgt) : tgt;
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_val  = 1'b0;
		wr_nxt  = 1'b0;
		wr_prv  = 1'b0;
		wr_addr = '0;
		wr_data = '{val: DATA_WIDTH'(val_q), nxt: '0, prv: '0};
		unique case (state_q)
			ST_INIT: begin
				wr_nxt  = 1'b1;
				wr_prv  = 1'b1;
				wr_addr = init_cnt_q;
				if ((init_cnt_q != '0) && (init_cnt_q != LW'(CAPACITY))) begin
					wr_data.nxt = LW'(init_cnt_q + 1'b1);
				end
				if (init_cnt_q == LW'(CAPACITY)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (rej) begin
						state_d = ST_DONE;
					end else begin
						rd_en   = 1'b1;
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (!walk_end) begin
					rd_en   = 1'b1;
					rd_addr = walk_next;
				end else if (read_op) begin
					state_d = ST_DONE;
				end else if (del_op) begin
					wr_nxt      = 1'b1;
					wr_prv      = 1'b1;
					wr_addr     = p_q;
					wr_data.nxt = free_head_q;
					state_d     = ST_DEL_Q;
				end else begin
					rd_en       = 1'b1;
					rd_addr     = free_head_q;
					wr_nxt      = 1'b1;
					wr_addr     = p_q;
					wr_data.nxt = free_head_q;
					state_d     = ST_LINK_S;
				end
			end
			ST_DEL_Q: begin
				wr_nxt      = 1'b1;
				wr_addr     = q_q;
				wr_data.nxt = n_q;
				state_d     = ST_DEL_N;
			end
			ST_DEL_N: begin
				wr_prv      = 1'b1;
				wr_addr     = n_q;
				wr_data.prv = q_q;
				state_d     = ST_DONE;
			end
			ST_LINK_S: begin
				wr_prv      = 1'b1;
				wr_addr     = n_q;
				wr_data.prv = free_head_q;
				state_d     = ST_LINK_N;
			end
			ST_LINK_N: begin
				wr_val      = 1'b1;
				wr_nxt      = 1'b1;
				wr_prv      = 1'b1;
				wr_addr     = free_head_q;
				wr_data.nxt = n_q;
				wr_data.prv = p_q;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_val) begin
			mem[wr_addr].val <= wr_data.val;
		end
		if (wr_nxt) begin
			mem[wr_addr].nxt <= wr_data.nxt;
		end
		if (wr_prv) begin
			mem[wr_addr].prv <= wr_data.prv;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_cnt_q  <= '0;
			free_head_q <= LW'(1);
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT) begin
				init_cnt_q <= init_cnt_q + 1'b1;
			end
			if ((state_q == ST_WALK) && walk_end && del_op) begin
				free_head_q <= p_q;
			end
			if (state_q == ST_LINK_N) begin
				free_head_q <= rd_data_q.nxt;
				len_q       <= len_q + 1'b1;
			end
			if (state_q == ST_DEL_N) begin
				len_q <= len_q - 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= in_mode;
			val_q    <= in_value;
			status_q <= rej ? rej_status : plle_pkg::STATUS_OK;
			rv_q     <= '0;
			p_q      <= '0;
			steps_q  <= steps_init;
			back_q   <= back_init;
		end
		if (state_q == ST_WALK) begin
			if (!walk_end) begin
				p_q     <= walk_next;
				steps_q <= steps_q - 1'b1;
			end else begin
				q_q <= rd_data_q.prv;
				n_q <= rd_data_q.nxt;
				if (read_op || del_op) begin
					rv_q <= val_ext[RVW-1:0];
				end
			end
		end
		if (out_load) begin
			out_data_q <= {{PADW{1'b0}}, (len_q == '0), OLW'(len_q), rv_q, status_q};
		end
	end

	`PLLE_ASSERT_NEVER(a_len_bound, len_q > LW'(CAPACITY), "list length beyond capacity")
	`PLLE_ASSERT(a_free_full, (state_q == ST_IDLE) |-> (full == (len_q == LW'(CAPACITY))), "free mismatch")
	`PLLE_ASSERT(a_walk_bound, (state_q == ST_WALK) |-> (steps_q <= CMPW'(len_q) + 1'b1), "walk too long")
	`PLLE_ASSERT(a_link_len, (state_q == ST_LINK_N) |=> (len_q == $past(len_q) + 1'b1), "no growth")

endmodule

// ===== verif/positional_linked_list_engine_top_tb.sv =====
// Testbench for positional_linked_list_engine_top: random and directed list operations on the
// stream ports, checked against a cycle-free list predictor kept in the bench.
// Depends on plle_pkg and the engine RTL only.
module positional_linked_list_engine_top_tb;

	localparam int CAP = plle_pkg::CAPACITY_DEFAULT;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = CAP / 2 + 16;

	localparam logic [plle_pkg::MODE_W-1:0] MODE_RSVD_LO = 3'd5;
	localparam logic [plle_pkg::MODE_W-1:0] MODE_RSVD_MID = 3'd6;
	localparam logic [plle_pkg::MODE_W-1:0] MODE_RSVD_HI = 3'd7;

	typedef struct packed {
		logic signed [plle_pkg::VALUE_W-1:0] value;
		logic [plle_pkg::POS_W-1:0] position;
		logic [plle_pkg::MODE_W-1:0] mode;
	} list_op_t;

	typedef struct packed {
		logic empty_res;
		logic [plle_pkg::LEN_W-1:0] length;
		logic [plle_pkg::RV_W-1:0] read_value;
		logic [plle_pkg::STATUS_W-1:0] status;
	} list_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [plle_pkg::S_TDATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [plle_pkg::M_TDATA_W-1:0] m_tdata;

	list_op_t pending_ops[$];
	list_result_t expected_results[$];
	bit in_taken;
	bit rx_hold;
	bit stall_request;
	int tx_idle_pct;
	int rx_idle_pct;
	int fail_count;
	int cycle_count;
	int gen_len;

	int node_next[0:CAP];
	int node_prev[0:CAP];
	logic [plle_pkg::VALUE_W-1:0] node_data[1:CAP];
	int free_top;
	int list_len;

	positional_linked_list_engine_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #6 clk = ~clk;

	function automatic int node_at(int steps);
		int p;
		p = 0;
		for (int k = 0; k < steps; k++)
			p = node_next[p];
		return p;
	endfunction

	function automatic void link_in(int after, logic [plle_pkg::VALUE_W-1:0] v);
		int s;
		int n;
		s = free_top;
		n = node_next[after];
		free_top = node_next[s];
		node_data[s] = v;
		node_next[s] = n;
		node_prev[s] = after;
		node_prev[n] = s;
		node_next[after] = s;
		list_len++;
	endfunction

	function automatic list_result_t apply_list_op(list_op_t op);
		list_result_t r;
		int pos;
		int p;
		bit full;
		r = '0;
		pos = int'(op.position);
		full = (free_top == 0);
		case (op.mode)
			plle_pkg::MODE_READ, plle_pkg::MODE_DELETE: begin
				if (pos < 1 || pos > list_len) begin
					r.status = plle_pkg::STATUS_RANGE;
				end else begin
					p = node_at(pos);
					r.read_value = node_data[p];
					if (op.mode == plle_pkg::MODE_DELETE) begin
						node_next[node_prev[p]] = node_next[p];
						node_prev[node_next[p]] = node_prev[p];
						node_next[p] = free_top;
						node_prev[p] = 0;
						free_top = p;
						list_len--;
					end
				end
			end
			plle_pkg::MODE_INSERT: begin
				if (pos < 1 || pos > list_len + 1)
					r.status = plle_pkg::STATUS_RANGE;
				else if (full)
					r.status = plle_pkg::STATUS_FULL;
				else
					link_in(node_at(pos - 1), op.value);
			end
			plle_pkg::MODE_PUSH_FRONT, plle_pkg::MODE_PUSH_BACK: begin
				if (full)
					r.status = plle_pkg::STATUS_FULL;
				else
					link_in(op.mode == plle_pkg::MODE_PUSH_FRONT ? 0 : node_prev[0], op.value);
			end
			default: r.status = plle_pkg::STATUS_RANGE;
		endcase
		r.length = plle_pkg::LEN_W'(list_len);
		r.empty_res = (list_len == 0);
		return r;
	endfunction

	task automatic check_field(string name, logic [plle_pkg::RV_W-1:0] exp_v,
			logic [plle_pkg::RV_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	task automatic queue_op(logic [plle_pkg::MODE_W-1:0] mode, int pos,
			logic [plle_pkg::VALUE_W-1:0] v);
		list_op_t op;
		op.mode = mode;
		op.position = plle_pkg::POS_W'(pos);
		op.value = v;
		pending_ops.push_back(op);
		case (mode)
			plle_pkg::MODE_INSERT:
				if (pos >= 1 && pos <= gen_len + 1 && gen_len < CAP) gen_len++;
			plle_pkg::MODE_DELETE:
				if (pos >= 1 && pos <= gen_len) gen_len--;
			plle_pkg::MODE_PUSH_FRONT, plle_pkg::MODE_PUSH_BACK:
				if (gen_len < CAP) gen_len++;
			default: ;
		endcase
	endtask

	task automatic queue_random_op(int grow_pct);
		logic [plle_pkg::MODE_W-1:0] mode;
		int r;
		int pos;
		int top;
		r = $urandom_range(99);
		if (r < 4) begin
			mode = plle_pkg::MODE_W'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
		end else if (r < 4 + grow_pct) begin
			case ($urandom_range(2))
				0: mode = plle_pkg::MODE_INSERT;
				1: mode = plle_pkg::MODE_PUSH_FRONT;
				default: mode = plle_pkg::MODE_PUSH_BACK;
			endcase
		end else begin
			mode = $urandom_range(1) ? plle_pkg::MODE_READ : plle_pkg::MODE_DELETE;
		end
		top = (mode == plle_pkg::MODE_INSERT) ? gen_len + 1 : gen_len;
		if (top < 1)
			top = 1;
		r = $urandom_range(99);
		if (r < 85) begin
			pos = $urandom_range(top, 1);
		end else if (r < 93) begin
			case ($urandom_range(2))
				0: pos = 0;
				1: pos = gen_len + 1;
				default: pos = gen_len + 2;
			endcase
		end else begin
			pos = $urandom_range((1 << plle_pkg::POS_W) - 1);
		end
		queue_op(mode, pos, $urandom);
	endtask

	task automatic wait_drained();
		while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		in_taken = arst_n && s_tvalid && s_tready;
		if (in_taken)
			expected_results.push_back(apply_list_op(list_op_t'(s_tdata[$bits(list_op_t)-1:0])));
		if (arst_n && m_tvalid && m_tready) begin
			got = list_result_t'(m_tdata[$bits(list_result_t)-1:0]);
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", plle_pkg::RV_W'(want.status),
					plle_pkg::RV_W'(got.status));
				check_field("read_value", want.read_value, got.read_value);
				check_field("length", plle_pkg::RV_W'(want.length),
					plle_pkg::RV_W'(got.length));
				check_field("empty_res", plle_pkg::RV_W'(want.empty_res),
					plle_pkg::RV_W'(got.empty_res));
			end
		end
	end

	always @(negedge clk) begin
		if (!s_tvalid || in_taken) begin
			if (pending_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= plle_pkg::S_TDATA_W'(pending_ops.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	initial begin
		rx_hold = 1'b0;
		wait (stall_request);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		in_taken = 1'b0;
		stall_request = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		gen_len = 0;
		for (int i = 0; i <= CAP; i++) begin
			node_next[i] = (i == 0 || i == CAP) ? 0 : i + 1;
			node_prev[i] = 0;
		end
		free_top = 1;
		list_len = 0;

		tx_idle_pct = 28;
		rx_idle_pct = 84;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_op(plle_pkg::MODE_READ, 1, $urandom);
		queue_op(plle_pkg::MODE_DELETE, 0, $urandom);
		queue_op(plle_pkg::MODE_INSERT, 2, $urandom);
		queue_op(plle_pkg::MODE_INSERT, 1, 32'h8000_0000);
		queue_op(plle_pkg::MODE_PUSH_FRONT, 0, 32'h7fff_ffff);
		queue_op(plle_pkg::MODE_PUSH_BACK, 511, 32'hffff_ffff);
		queue_op(plle_pkg::MODE_INSERT, 4, 32'h0000_0000);
		queue_op(plle_pkg::MODE_INSERT, 0, $urandom);
		queue_op(plle_pkg::MODE_READ, 1, $urandom);
		queue_op(plle_pkg::MODE_READ, 4, $urandom);
		queue_op(plle_pkg::MODE_READ, 5, $urandom);
		queue_op(plle_pkg::MODE_READ, 511, $urandom);
		queue_op(plle_pkg::MODE_INSERT, 3, $urandom);
		queue_op(MODE_RSVD_LO, 1, $urandom);
		queue_op(MODE_RSVD_MID, 256, $urandom);
		queue_op(MODE_RSVD_HI, 511, $urandom);
		queue_op(plle_pkg::MODE_DELETE, 5, $urandom);
		queue_op(plle_pkg::MODE_DELETE, 1, $urandom);
		queue_op(plle_pkg::MODE_DELETE, 2, $urandom);
		queue_op(plle_pkg::MODE_DELETE, 3, $urandom);
		queue_op(plle_pkg::MODE_DELETE, 1, $urandom);
		queue_op(plle_pkg::MODE_DELETE, 1, $urandom);
		queue_op(plle_pkg::MODE_DELETE, 1, $urandom);
		queue_op(plle_pkg::MODE_PUSH_BACK, 0, 32'h5555_5555);
		queue_op(plle_pkg::MODE_PUSH_FRONT, 0, 32'haaaa_aaaa);
		repeat (90) queue_random_op(45);
		wait_drained();

		tx_idle_pct = 84;
		rx_idle_pct = 28;
		while (gen_len < CAP) begin
			case ($urandom_range(9))
				0: queue_op(plle_pkg::MODE_INSERT, $urandom_range(gen_len + 1, 1), $urandom);
				1, 2, 3, 4: queue_op(plle_pkg::MODE_PUSH_FRONT, $urandom_range(511), $urandom);
				default: queue_op(plle_pkg::MODE_PUSH_BACK, $urandom_range(511), $urandom);
			endcase
		end
		queue_op(plle_pkg::MODE_PUSH_FRONT, 0, $urandom);
		queue_op(plle_pkg::MODE_PUSH_BACK, 0, $urandom);
		queue_op(plle_pkg::MODE_INSERT, 1, $urandom);
		queue_op(plle_pkg::MODE_INSERT, CAP + 1, $urandom);
		queue_op(plle_pkg::MODE_INSERT, CAP + 2, $urandom);
		queue_op(plle_pkg::MODE_READ, CAP, $urandom);
		queue_op(plle_pkg::MODE_DELETE, CAP, $urandom);
		queue_op(plle_pkg::MODE_PUSH_BACK, 0, $urandom);
		queue_op(plle_pkg::MODE_INSERT, CAP, $urandom);
		repeat (25) queue_random_op(45);
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		stall_request = 1'b1;
		repeat (50) queue_random_op(20);
		repeat (30) queue_random_op(50);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/plle_pkg.sv
rtl/core/positional_linked_list_engine_top.sv
verif/positional_linked_list_engine_top_tb.sv
